### rtl/core/qfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfr_pkg
// Types and constants shared by the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package qfr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;
    // sums of three matrix elements plus one
    localparam int SUM_W     = DATA_W + 3;
    // pairwise sums and differences of matrix elements
    localparam int PAIR_W    = DATA_W + 2;
    localparam int MAG_W     = DATA_W + 1;
    // radicand arg << FRAC_BITS, kept even for two bits per root step
    localparam int RAD_W     = 32;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_REM_W  = ROOT_W + 3;
    // divider: numerator mag << FRAC_BITS plus root, denominator 2 * root
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int DEN_W     = ROOT_W + 1;
    localparam int QUO_W     = 23;
    localparam int DIV_REM_W = DEN_W + 1;
    localparam int LANES     = 3;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } qfr_axis_t;

    typedef enum logic [1:0] {
        COMP_W = 2'd0,
        COMP_X = 2'd1,
        COMP_Y = 2'd2,
        COMP_Z = 2'd3
    } qfr_comp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m13;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] m23;
        logic signed [DATA_W-1:0] m31;
        logic signed [DATA_W-1:0] m32;
        logic signed [DATA_W-1:0] m33;
    } qfr_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] qw;
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
        logic                     degenerate;
    } qfr_out_t;

    // travels alongside the square root pipeline
    typedef struct packed {
        logic                          valid;
        logic                          degen;
        qfr_comp_t                     root_sel;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][MAG_W-1:0]   mag;
    } qfr_side_t;

    // travels alongside the divider pipeline
    typedef struct packed {
        logic             valid;
        logic             degen;
        qfr_comp_t        root_sel;
        logic [LANES-1:0] neg;
        logic [ROOT_W-1:0] root;
    } qfr_dside_t;

endpackage

### rtl/core/qfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfr_front
// Trace test, axis choice, root argument and the three numerators.
// ----------------------------------------------------------------------------
module qfr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  qfr_pkg::qfr_in_t            mat,
    output qfr_pkg::qfr_side_t          side,
    output logic [qfr_pkg::RAD_W-1:0]   rad
);
    import qfr_pkg::*;

    qfr_side_t         side_reg, side_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;

    logic signed [SUM_W-1:0]  a11, a22, a33, trace, arg;
    logic signed [PAIR_W-1:0] p12, p13, p21, p23, p31, p32;
    logic signed [PAIR_W-1:0] lane [LANES];
    qfr_axis_t                axis;
    logic                     tpos;

    always_comb
    begin
        a11 = SUM_W'(mat.m11);
        a22 = SUM_W'(mat.m22);
        a33 = SUM_W'(mat.m33);
        p12 = PAIR_W'(mat.m12);
        p13 = PAIR_W'(mat.m13);
        p21 = PAIR_W'(mat.m21);
        p23 = PAIR_W'(mat.m23);
        p31 = PAIR_W'(mat.m31);
        p32 = PAIR_W'(mat.m32);
        trace = a11 + a22 + a33;
        tpos  = trace > 0;

        // strictly greater takes over, lower index wins a tie
        axis = AXIS_X;
        if (a22 > a11)
        begin
            axis = AXIS_Y;
        end
        if (a33 > ((axis == AXIS_Y) ? a22 : a11))
        begin
            axis = AXIS_Z;
        end

        side_next.valid = in_valid;
        if (tpos)
        begin
            arg = trace + SUM_W'(ONE);
            side_next.root_sel = COMP_W;
            lane[0] = p32 - p23;
            lane[1] = p13 - p31;
            lane[2] = p21 - p12;
        end
        else
        begin
            unique case (axis)
                AXIS_Y:
                begin
                    arg = a22 - a33 - a11 + SUM_W'(ONE);
                    side_next.root_sel = COMP_Y;
                    lane[0] = p13 - p31;
                    lane[1] = p12 + p21;
                    lane[2] = p32 + p23;
                end
                AXIS_Z:
                begin
                    arg = a33 - a11 - a22 + SUM_W'(ONE);
                    side_next.root_sel = COMP_Z;
                    lane[0] = p21 - p12;
                    lane[1] = p13 + p31;
                    lane[2] = p23 + p32;
                end
                default:
                begin
                    arg = a11 - a22 - a33 + SUM_W'(ONE);
                    side_next.root_sel = COMP_X;
                    lane[0] = p32 - p23;
                    lane[1] = p21 + p12;
                    lane[2] = p31 + p13;
                end
            endcase
        end

        side_next.degen = (arg <= 0);
        for (int l = 0; l < LANES; l++)
        begin
            side_next.neg[l] = lane[l][PAIR_W-1];
            side_next.mag[l] = lane[l][PAIR_W-1] ? MAG_W'(-lane[l]) : MAG_W'(lane[l]);
        end
        rad_next = {1'b0, arg[RAD_W-FRAC_BITS-2:0], {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
    end

    assign side = side_reg;
    assign rad  = rad_reg;

endmodule

### rtl/core/qfr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfr_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module qfr_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qfr_pkg::qfr_side_t           side_in,
    input  logic [qfr_pkg::RAD_W-1:0]    rad,
    output qfr_pkg::qfr_side_t           side_out,
    output logic [qfr_pkg::ROOT_W-1:0]   root
);
    import qfr_pkg::*;

    qfr_side_t           side_reg [1:ROOT_W];
    logic [RAD_W-1:0]    rad_reg  [1:ROOT_W];
    logic [SQ_REM_W-1:0] rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [1:ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_step
        qfr_side_t           side_cur;
        logic [RAD_W-1:0]    rad_cur;
        logic [SQ_REM_W-1:0] rem_cur;
        logic [ROOT_W-1:0]   root_cur;
        logic [SQ_REM_W-1:0] rin, trial, rem_next;
        logic                ge;

        // first stage takes the front end outputs directly
        if (s == 0)
        begin : g_head
            assign side_cur = side_in;
            assign rad_cur  = rad;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end
        else
        begin : g_body
            assign side_cur = side_reg[s];
            assign rad_cur  = rad_reg[s];
            assign rem_cur  = rem_reg[s];
            assign root_cur = root_reg[s];
        end

        always_comb
        begin
            rin      = {rem_cur[SQ_REM_W-3:0], rad_cur[RAD_W-1 -: 2]};
            trial    = SQ_REM_W'({root_cur, 2'b01});
            ge       = rin >= trial;
            rem_next = ge ? rin - trial : rin;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[s+1] <= '0;
            end
            else
            begin
                side_reg[s+1] <= side_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[s+1]  <= {rad_cur[RAD_W-3:0], 2'b00};
            rem_reg[s+1]  <= rem_next;
            root_reg[s+1] <= {root_cur[ROOT_W-2:0], ge};
        end
    end

    assign side_out = side_reg[ROOT_W];
    assign root     = root_reg[ROOT_W];

endmodule

### rtl/core/qfr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfr_div
// Three pipelined restoring dividers: round(mag * 2^frac / (2 * root)).
// ----------------------------------------------------------------------------
module qfr_div (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  qfr_pkg::qfr_side_t                            side_in,
    input  logic [qfr_pkg::ROOT_W-1:0]                    root,
    output qfr_pkg::qfr_dside_t                           side_out,
    output logic [qfr_pkg::LANES-1:0][qfr_pkg::QUO_W-1:0] quo
);
    import qfr_pkg::*;

    qfr_dside_t           side_reg [1:QUO_W];
    logic [DEN_W-1:0]     den_reg  [1:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]     nb_reg  [1:QUO_W];
    logic [LANES-1:0][DIV_REM_W-1:0] rem_reg [1:QUO_W];
    logic [LANES-1:0][QUO_W-1:0]     quo_reg [1:QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        qfr_dside_t                      side_cur;
        logic [DEN_W-1:0]                den_cur;
        logic [LANES-1:0][QUO_W-1:0]     nb_cur;
        logic [LANES-1:0][DIV_REM_W-1:0] rem_cur;
        logic [LANES-1:0][QUO_W-1:0]     quo_cur;
        logic [LANES-1:0][DIV_REM_W-1:0] rem_next;
        logic [LANES-1:0]                ge;

        if (s == 0)
        begin : g_head
            always_comb
            begin
                logic [NUM_W-1:0] num;
                side_cur.valid    = side_in.valid;
                side_cur.degen    = side_in.degen;
                side_cur.root_sel = side_in.root_sel;
                side_cur.neg      = side_in.neg;
                side_cur.root     = root;
                den_cur           = {root, 1'b0};
                for (int l = 0; l < LANES; l++)
                begin
                    // adding the root before dividing by twice the root rounds half up
                    num        = {side_in.mag[l], {FRAC_BITS{1'b0}}} + NUM_W'(root);
                    rem_cur[l] = DIV_REM_W'(num[NUM_W-1:QUO_W]);
                    nb_cur[l]  = num[QUO_W-1:0];
                    quo_cur[l] = '0;
                end
            end
        end
        else
        begin : g_body
            assign side_cur = side_reg[s];
            assign den_cur  = den_reg[s];
            assign nb_cur   = nb_reg[s];
            assign rem_cur  = rem_reg[s];
            assign quo_cur  = quo_reg[s];
        end

        always_comb
        begin
            logic [DIV_REM_W-1:0] rin;
            for (int l = 0; l < LANES; l++)
            begin
                rin         = {rem_cur[l][DIV_REM_W-2:0], nb_cur[l][QUO_W-1]};
                ge[l]       = rin >= DIV_REM_W'(den_cur);
                rem_next[l] = ge[l] ? rin - DIV_REM_W'(den_cur) : rin;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[s+1] <= '0;
            end
            else
            begin
                side_reg[s+1] <= side_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_cur;
            rem_reg[s+1] <= rem_next;
            for (int l = 0; l < LANES; l++)
            begin
                nb_reg[s+1][l]  <= {nb_cur[l][QUO_W-2:0], 1'b0};
                quo_reg[s+1][l] <= {quo_cur[l][QUO_W-2:0], ge[l]};
            end
        end
    end

    assign side_out = side_reg[QUO_W];
    assign quo      = quo_reg[QUO_W];

endmodule

### rtl/core/quaternion_from_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix
// Rotation matrix (Q1.14) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low;
// busy is always low, so a new matrix may enter on every cycle.
// The matrix travels as one packed struct on matrix.
// Each result appears on result for exactly one cycle with done high.
// From the accepting edge to the edge that takes the result, a matrix passes
// the input register, front end, 16 square root stages (one root bit each),
// 23 divider stages (one quotient bit each, three lanes in parallel) and the
// output register. Throughput is one matrix per cycle.
// The results come out in the order the matrices went in.
// The receiver cannot stall; every result must be taken when done is high.
// Reset clears all valid bits, so no result is shown until a matrix has
// been taken after reset. When the root argument is not positive the four
// components are zero and degenerate is set; components saturate to +/-1.0.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  qfr_pkg::qfr_in_t  matrix,
    output logic              done,
    output qfr_pkg::qfr_out_t result
);
    import qfr_pkg::*;

    logic       in_valid_reg;
    qfr_in_t    mat_reg;
    qfr_side_t  front_side, sq_side;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    qfr_dside_t        dv_side;
    logic [LANES-1:0][QUO_W-1:0] quo;

    logic     done_reg, done_next;
    qfr_out_t result_reg, result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mat_reg    <= matrix;
        result_reg <= result_next;
    end

    qfr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .mat      (mat_reg),
        .side     (front_side),
        .rad      (rad)
    );

    qfr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (front_side),
        .rad      (rad),
        .side_out (sq_side),
        .root     (root)
    );

    qfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (sq_side),
        .root     (root),
        .side_out (dv_side),
        .quo      (quo)
    );

    always_comb
    begin
        logic [ROOT_W:0]          half;
        logic [DATA_W-1:0]        rootq;
        logic [DATA_W-1:0]        mag;
        logic signed [DATA_W-1:0] lane_q [LANES];

        // root component: (r + 1) >> 1, ties up
        half  = ({1'b0, dv_side.root} + (ROOT_W+1)'(1)) >> 1;
        rootq = (half > (ROOT_W+1)'(ONE)) ? ONE : DATA_W'(half);
        for (int l = 0; l < LANES; l++)
        begin
            mag       = (quo[l] > QUO_W'(ONE)) ? ONE : DATA_W'(quo[l]);
            lane_q[l] = dv_side.neg[l] ? -$signed(mag) : $signed(mag);
        end

        done_next = dv_side.valid;
        unique case (dv_side.root_sel)
            COMP_W:
            begin
                result_next.qw = $signed(rootq);
                result_next.qx = lane_q[0];
                result_next.qy = lane_q[1];
                result_next.qz = lane_q[2];
            end
            COMP_X:
            begin
                result_next.qw = lane_q[0];
                result_next.qx = $signed(rootq);
                result_next.qy = lane_q[1];
                result_next.qz = lane_q[2];
            end
            COMP_Y:
            begin
                result_next.qw = lane_q[0];
                result_next.qx = lane_q[1];
                result_next.qy = $signed(rootq);
                result_next.qz = lane_q[2];
            end
            default:
            begin
                result_next.qw = lane_q[0];
                result_next.qx = lane_q[1];
                result_next.qy = lane_q[2];
                result_next.qz = $signed(rootq);
            end
        endcase
        result_next.degenerate = dv_side.degen;
        if (dv_side.degen)
        begin
            result_next.qw = '0;
            result_next.qx = '0;
            result_next.qy = '0;
            result_next.qz = '0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sim/quaternion_from_rotation_matrix_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_from_rotation_matrix_test
// Sends directed and random matrices through the quaternion pipeline and
// checks every result against a bit-exact integer model of the conversion.
// ----------------------------------------------------------------------------
module quaternion_from_rotation_matrix_test;
    import qfr_pkg::*;

    localparam int N_RANDOM  = 650;
    localparam int LATENCY   = 42;
    localparam int MAX_CYCLE = 200000;

    class quat_scoreboard;
        qfr_out_t pending_quats[$];
        int       mismatches;
        int       checked;
        int       unexpected;

        function new();
            mismatches = 0;
            checked    = 0;
            unexpected = 0;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // round to nearest, ties away from zero
        static function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = (mag + (den >>> 1)) / den;
            return (num < 0) ? -q : q;
        endfunction

        static function logic [DATA_W-1:0] clamp_comp(longint v);
            longint one;
            one = longint'(1) << FRAC_BITS;
            if (v > one) v = one;
            if (v < -one) v = -one;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[DATA_W-1:0];
        endfunction

        static function qfr_out_t convert(qfr_in_t mx);
            longint m[3][3];
            longint q[4];
            longint one, trace, arg, den;
            longint unsigned r;
            int i, j, k;
            qfr_out_t o;
            one = longint'(1) << FRAC_BITS;
            m[0][0] = mx.m11; m[0][1] = mx.m12; m[0][2] = mx.m13;
            m[1][0] = mx.m21; m[1][1] = mx.m22; m[1][2] = mx.m23;
            m[2][0] = mx.m31; m[2][1] = mx.m32; m[2][2] = mx.m33;
            o = '0;
            trace = m[0][0] + m[1][1] + m[2][2];
            if (trace > 0)
            begin
                arg  = trace + one;
                r    = int_sqrt(longint'(arg) << FRAC_BITS);
                den  = 2 * longint'(r);
                q[0] = longint'((r + 1) >> 1);
                q[1] = round_div((m[2][1] - m[1][2]) * one, den);
                q[2] = round_div((m[0][2] - m[2][0]) * one, den);
                q[3] = round_div((m[1][0] - m[0][1]) * one, den);
            end
            else
            begin
                i = 0;
                if (m[1][1] > m[0][0]) i = 1;
                if (m[2][2] > m[i][i]) i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                arg = m[i][i] - m[j][j] - m[k][k] + one;
                r = (arg <= 0) ? 0 : int_sqrt(longint'(arg) << FRAC_BITS);
                if (r == 0)
                begin
                    o.degenerate = 1'b1;
                    return o;
                end
                den = 2 * longint'(r);
                q[1 + i] = longint'((r + 1) >> 1);
                q[0]     = round_div((m[k][j] - m[j][k]) * one, den);
                q[1 + j] = round_div((m[j][i] + m[i][j]) * one, den);
                q[1 + k] = round_div((m[k][i] + m[i][k]) * one, den);
            end
            o.qw = clamp_comp(q[0]);
            o.qx = clamp_comp(q[1]);
            o.qy = clamp_comp(q[2]);
            o.qz = clamp_comp(q[3]);
            return o;
        endfunction

        function void note_matrix(qfr_in_t mx);
            pending_quats.push_back(convert(mx));
        endfunction

        function void check_quat(qfr_out_t got);
            qfr_out_t exp_q;
            if (pending_quats.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_q = pending_quats.pop_front();
            checked++;
            if (got !== exp_q)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp w=%0d x=%0d y=%0d z=%0d dg=%b",
                              " got w=%0d x=%0d y=%0d z=%0d dg=%b"},
                        exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.degenerate,
                        got.qw, got.qx, got.qy, got.qz, got.degenerate);
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    qfr_in_t  matrix;
    logic     done;
    qfr_out_t result;

    quat_scoreboard sb;
    int cycle_count;
    int n_sent;
    int n_degen;

    quaternion_from_rotation_matrix uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .matrix (matrix),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("quaternion_from_rotation_matrix_test: FAIL");
            $finish;
        end
    end

    // the receiver cannot stall, so every strobe is checked
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (result.degenerate) n_degen++;
            sb.check_quat(result);
        end
    end

    // holds start for one accepting edge, with a gap of idle cycles after it
    task automatic send_matrix(input qfr_in_t mx, input int gap);
        matrix <= mx;
        start  <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_matrix(mx);
        n_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return DATA_W'($urandom_range(0, 65535));
            3: return 16'sd0;
            default: return DATA_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // random rotation built from a random unit quaternion, in Q1.14
    function automatic qfr_in_t rand_rotation();
        real w, x, y, z, n, s;
        real e[9];
        qfr_in_t mx;
        w = $urandom_range(0, 20000) - 10000.0;
        x = $urandom_range(0, 20000) - 10000.0;
        y = $urandom_range(0, 20000) - 10000.0;
        z = $urandom_range(0, 20000) - 10000.0;
        n = w * w + x * x + y * y + z * z;
        if (n < 1.0)
        begin
            w = 1.0;
            n = 1.0;
        end
        s = 2.0 / n;
        e[0] = 1 - s * (y * y + z * z); e[1] = s * (x * y - w * z);
        e[2] = s * (x * z + w * y);     e[3] = s * (x * y + w * z);
        e[4] = 1 - s * (x * x + z * z); e[5] = s * (y * z - w * x);
        e[6] = s * (x * z - w * y);     e[7] = s * (y * z + w * x);
        e[8] = 1 - s * (x * x + y * y);
        mx.m11 = DATA_W'($rtoi(e[0] * 16384.0));
        mx.m12 = DATA_W'($rtoi(e[1] * 16384.0));
        mx.m13 = DATA_W'($rtoi(e[2] * 16384.0));
        mx.m21 = DATA_W'($rtoi(e[3] * 16384.0));
        mx.m22 = DATA_W'($rtoi(e[4] * 16384.0));
        mx.m23 = DATA_W'($rtoi(e[5] * 16384.0));
        mx.m31 = DATA_W'($rtoi(e[6] * 16384.0));
        mx.m32 = DATA_W'($rtoi(e[7] * 16384.0));
        mx.m33 = DATA_W'($rtoi(e[8] * 16384.0));
        return mx;
    endfunction

    function automatic qfr_in_t diag(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                     logic [DATA_W-1:0] c, logic [DATA_W-1:0] off);
        qfr_in_t mx;
        mx = {9{off}};
        mx.m11 = a;
        mx.m22 = b;
        mx.m33 = c;
        return mx;
    endfunction

    initial
    begin
        qfr_in_t mx;
        int burst, gap, k;
        sb          = new();
        cycle_count = 0;
        n_sent      = 0;
        n_degen     = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        matrix      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, axis flips on each diagonal, ties, degenerate and extremes
        send_matrix(diag(16'sd16384, 16'sd16384, 16'sd16384, 16'sd0), 0);
        send_matrix(diag(16'sd16384, -16'sd16384, -16'sd16384, 16'sd0), 0);
        send_matrix(diag(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd0), 1);
        send_matrix(diag(-16'sd16384, -16'sd16384, 16'sd16384, 16'sd0), 0);
        send_matrix(diag(16'sd0, 16'sd0, 16'sd0, 16'sd0), 2);
        send_matrix(diag(-16'sd16384, -16'sd16384, -16'sd16384, 16'sd0), 0);
        send_matrix(diag(16'sd5000, 16'sd5000, -16'sd10000, 16'sd100), 0);
        send_matrix(diag(-16'sd8000, 16'sd3000, 16'sd3000, -16'sd200), 0);
        send_matrix(diag(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff), 0);
        send_matrix(diag(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000), 3);
        send_matrix(diag(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff), 0);
        send_matrix(diag(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000), 0);
        send_matrix(diag(16'sd1, 16'sd0, 16'sd0, 16'shffff), 0);
        send_matrix(diag(-16'sd1, 16'sd0, 16'sd0, 16'sh5555), 0);
        send_matrix(diag(16'sd0, 16'sd0, 16'sd0, 16'shaaaa), 1);
        send_matrix(diag(16'sd16384, 16'sd0, 16'sd0, 16'sd16384), 0);
        send_matrix(diag(-16'sd16384, 16'sd0, 16'sd16384, -16'sd16384), 0);
        send_matrix(diag(16'sd0, 16'sh8000, 16'sh7fff, 16'sd0), 0);

        // hold off until the pipeline has drained
        start <= 1'b0;
        while (sb.pending_quats.size() != 0)
            @(posedge clk);

        k = 0;
        while (k < N_RANDOM)
        begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && k < N_RANDOM; b++)
            begin
                if ($urandom_range(0, 3) != 0)
                    mx = rand_rotation();
                else
                    for (int f = 0; f < 9; f++)
                        mx[f*DATA_W +: DATA_W] = rand_elem();
                gap = (b == burst - 1) ? $urandom_range(0, 12) : 0;
                send_matrix(mx, gap);
                k++;
            end
            if (k == N_RANDOM / 2)
            begin
                start <= 1'b0;
                while (sb.pending_quats.size() != 0)
                    @(posedge clk);
            end
        end
        start <= 1'b0;

        while (sb.pending_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("sent %0d matrices, checked %0d quaternions (%0d degenerate)",
            n_sent, sb.checked, n_degen);
        $display("mismatches %0d, unexpected results %0d", sb.mismatches, sb.unexpected);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_quats.size() == 0)
            $display("quaternion_from_rotation_matrix_test: PASS");
        else
            $display("quaternion_from_rotation_matrix_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/qfr_pkg.sv
rtl/core/qfr_front.sv
rtl/core/qfr_sqrt.sv
rtl/core/qfr_div.sv
rtl/core/quaternion_from_rotation_matrix.sv
sim/quaternion_from_rotation_matrix_test.sv
